@@ rtl/core/tspes_pkg.sv @@
// Shared types and constants of the transport stream PID filter and PES assembler.
// Depends on nothing; every core module imports it.
`timescale 1ns / 1ps
package tspes_pkg;

  // Packet status codes
  localparam logic [2:0] ST_IGNORED   = 3'd0;
  localparam logic [2:0] ST_LOST      = 3'd1;
  localparam logic [2:0] ST_STARTED   = 3'd2;
  localparam logic [2:0] ST_FIN_START = 3'd3;
  localparam logic [2:0] ST_CONTINUE  = 3'd4;
  localparam logic [2:0] ST_FINISHED  = 3'd5;

  // Register addresses
  localparam logic [2:0] ADDR_TARGET_PID = 3'd0;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [8:0]  PCR_MUL   = 9'd300;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_report;
    logic [2:0]  status;
    logic [41:0] pcr;
    logic        pcr_present;
    logic        pes_first;
    logic        last;
  } out_item_t;

  // Results of one input byte toward the queue
  typedef struct packed {
    logic [1:0] n;
    out_item_t  d0;
    out_item_t  d1;
  } push_t;

endpackage

@@ rtl/core/tspes_front.sv @@
// Front end: packet parser, PID and continuity filter, PCR capture, PES tracking.
// Depends on tspes_pkg. Emits up to two result items per byte.
`timescale 1ns / 1ps
module tspes_front #(
  parameter int PACKET_BYTES = 188
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  tspes_pkg::in_item_t in_d,
  input  logic [12:0]       target_pid,
  output tspes_pkg::push_t  push
);
  import tspes_pkg::*;

  localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);

  logic [7:0]  pos_r, pos_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic [7:0]  af_len_r, af_len_nxt;
  logic [7:0]  af_flags_r, af_flags_nxt;
  logic [47:0] pcr_sh_r, pcr_sh_nxt;
  logic [3:0]  last_cc_r, last_cc_nxt;
  logic        cc_seen_r, cc_seen_nxt;
  logic        asm_r, asm_nxt;
  logic [15:0] pes_len_r, pes_len_nxt;
  logic [16:0] pes_cnt_r, pes_cnt_nxt;
  logic [2:0]  pst_r, pst_nxt;
  logic [41:0] pcr_val_r;

  logic [7:0]  pos;
  logic [7:0]  b;
  logic [8:0]  start;
  logic [3:0]  expected;
  logic        pay, rep, first, pcr_ok;
  out_item_t   pay_res, rep_res;

  // Convert PCR base and extension; the shift register is stable long before the report
  always_ff @(posedge clk) begin
    pcr_val_r <= 42'(({9'd0, pcr_sh_r[47:15]} * {33'd0, PCR_MUL}) + {33'd0, pcr_sh_r[8:0]});
  end

  always_comb begin
    b            = in_d.in_byte;
    pos          = in_d.packet_start ? 8'd0 : pos_r;
    hdr_nxt      = hdr_r;
    af_len_nxt   = af_len_r;
    af_flags_nxt = af_flags_r;
    pcr_sh_nxt   = pcr_sh_r;
    last_cc_nxt  = last_cc_r;
    cc_seen_nxt  = cc_seen_r;
    asm_nxt      = asm_r;
    pes_len_nxt  = pes_len_r;
    pes_cnt_nxt  = pes_cnt_r;
    pst_nxt      = pst_r;
    pay          = 1'b0;
    rep          = 1'b0;
    first        = 1'b0;
    pcr_ok       = 1'b0;
    start        = 9'd4;
    expected     = 4'd0;

    if (pos == 8'd0) begin
      // Clear per-packet state
      hdr_nxt      = '0;
      af_len_nxt   = '0;
      af_flags_nxt = '0;
      pcr_sh_nxt   = '0;
      pst_nxt      = ST_IGNORED;
    end else if (pos <= 8'd3) begin
      // Collect header and decide the packet on its last byte
      hdr_nxt = {hdr_r[15:0], b};
      if (pos == 8'd3) begin
        expected = hdr_nxt[4] ? last_cc_r + 4'd1 : last_cc_r;
        if (hdr_nxt[20:8] != target_pid) begin
          pst_nxt = ST_IGNORED;
        end else if (cc_seen_r && hdr_nxt[3:0] != expected) begin
          pst_nxt     = ST_LOST;
          last_cc_nxt = hdr_nxt[3:0];
        end else begin
          cc_seen_nxt = 1'b1;
          last_cc_nxt = hdr_nxt[3:0];
          if (hdr_nxt[22]) begin
            pst_nxt     = asm_r ? ST_FIN_START : ST_STARTED;
            asm_nxt     = 1'b1;
            pes_cnt_nxt = '0;
            pes_len_nxt = '0;
          end else if (asm_r) begin
            pst_nxt = ST_CONTINUE;
          end else begin
            pst_nxt = ST_IGNORED;
          end
        end
      end
    end else begin
      // Walk the adaptation field, then forward payload
      if (hdr_r[5]) begin
        if (pos == 8'd4) begin
          af_len_nxt = b;
        end else if (pos == 8'd5 && af_len_r >= 8'd1) begin
          af_flags_nxt = b;
        end else if (pos >= 8'd6 && pos <= 8'd11 && af_len_r >= 8'd7 && af_flags_r[4]) begin
          pcr_sh_nxt = {pcr_sh_r[39:0], b};
        end
        start = 9'd5 + {1'b0, af_len_nxt};
      end
      if (hdr_r[4] && {1'b0, pos} >= start && pst_r >= ST_STARTED && pst_r <= ST_CONTINUE) begin
        pay   = 1'b1;
        first = (pst_r != ST_CONTINUE) && ({1'b0, pos} == start);
        if (pes_cnt_r == 17'd4) begin
          pes_len_nxt = {b, pes_len_r[7:0]};
        end else if (pes_cnt_r == 17'd5) begin
          pes_len_nxt = {pes_len_r[15:8], b};
        end
        if (pes_cnt_r < COUNT_MAX) begin
          pes_cnt_nxt = pes_cnt_r + 17'd1;
        end
      end
    end

    // Close the packet with its report
    if (pos == LAST_POS) begin
      rep = 1'b1;
      if (pst_nxt == ST_CONTINUE && pes_len_nxt != 16'd0
          && pes_cnt_nxt == {1'b0, pes_len_nxt} + 17'd6) begin
        pst_nxt = ST_FINISHED;
        asm_nxt = 1'b0;
      end
      pcr_ok = hdr_nxt[5] && af_len_nxt >= 8'd7 && af_flags_nxt[4];
    end

    pos_nxt = ({1'b0, pos} + 9'd1 >= 9'(PACKET_BYTES)) ? 8'd0 : pos + 8'd1;

    pay_res             = '0;
    pay_res.out_byte    = b;
    pay_res.status      = pst_r;
    pay_res.pes_first   = first;
    pay_res.last        = !rep;
    rep_res             = '0;
    rep_res.is_report   = 1'b1;
    rep_res.status      = pst_nxt;
    rep_res.pcr         = pcr_ok ? pcr_val_r : 42'd0;
    rep_res.pcr_present = pcr_ok;
    rep_res.last        = 1'b1;

    push.n  = fire ? ({1'b0, pay} + {1'b0, rep}) : 2'd0;
    push.d0 = pay ? pay_res : rep_res;
    push.d1 = rep_res;
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      hdr_r      <= '0;
      af_len_r   <= '0;
      af_flags_r <= '0;
      pcr_sh_r   <= '0;
      last_cc_r  <= '0;
      cc_seen_r  <= 1'b0;
      asm_r      <= 1'b0;
      pes_len_r  <= '0;
      pes_cnt_r  <= '0;
      pst_r      <= '0;
    end else if (fire) begin
      pos_r      <= pos_nxt;
      hdr_r      <= hdr_nxt;
      af_len_r   <= af_len_nxt;
      af_flags_r <= af_flags_nxt;
      pcr_sh_r   <= pcr_sh_nxt;
      last_cc_r  <= last_cc_nxt;
      cc_seen_r  <= cc_seen_nxt;
      asm_r      <= asm_nxt;
      pes_len_r  <= pes_len_nxt;
      pes_cnt_r  <= pes_cnt_nxt;
      pst_r      <= pst_nxt;
    end
  end

endmodule

@@ rtl/core/tspes_queue.sv @@
// Four-entry result queue taking up to two items per cycle, one out.
// Depends on tspes_pkg.
`timescale 1ns / 1ps
module tspes_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tspes_pkg::push_t     push,
  input  logic                 pop,
  output logic                 not_empty,
  output logic                 has_room,
  output tspes_pkg::out_item_t head
);
  import tspes_pkg::*;

  out_item_t  mem_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] cnt_r;

  assign not_empty = cnt_r != 3'd0;
  assign has_room  = cnt_r <= 3'd2;
  assign head      = mem_r[rptr_r];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wptr_r] <= push.d0;
    end
    if (push.n == 2'd2) begin
      mem_r[wptr_r + 2'd1] <= push.d1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + push.n;
      rptr_r <= rptr_r + {1'b0, pop};
      cnt_r  <= cnt_r + {1'b0, push.n} - {2'd0, pop};
    end
  end

endmodule

@@ rtl/core/tspes_back.sv @@
// Back end: output register that drains the result queue one item per cycle
// while the output is not stalled. Depends on tspes_pkg.
`timescale 1ns / 1ps
module tspes_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  tspes_pkg::out_item_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tspes_pkg::out_item_t out_data
);
  import tspes_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Load the next item when the register is free or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_head;
    end
  end

endmodule

@@ rtl/core/ts_pid_filter_pes_assembler_top.sv @@
// Top level of the transport stream PID filter and PES assembler.
// Depends on tspes_pkg, tspes_front, tspes_queue, tspes_back.
//
// Takes one stream byte per cycle and gives back forwarded PES payload bytes
// and one status report per packet. A byte is parsed in the cycle it is
// accepted; its results enter a four-entry queue and leave through an output
// register, one result per cycle unless the output side stalls. in_ready
// drops only while the queue holds more than two results, which happens only
// if the output side stalls. target_pid is written over the APB port at
// address 0 only while the block is idle; the user ensures it, not the block.
`timescale 1ns / 1ps
module ts_pid_filter_pes_assembler_top #(
  parameter int PACKET_BYTES = 188
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tspes_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tspes_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tspes_pkg::*;

  logic [12:0] target_pid_r;
  logic        fire, q_not_empty, q_room, q_pop;
  push_t       push;
  out_item_t   q_head;

  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_TARGET_PID) ? {19'd0, target_pid_r} : 32'd0;
  assign in_ready = q_room;
  assign fire     = in_valid && in_ready;

  // Write the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_pid_r <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_TARGET_PID) begin
      target_pid_r <= pwdata[12:0];
    end
  end

  tspes_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .in_d       (in_data),
    .target_pid (target_pid_r),
    .push       (push)
  );

  tspes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .has_room  (q_room),
    .head      (q_head)
  );

  tspes_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench of the transport stream PID filter and PES assembler.
// Depends on tspes_pkg and ts_pid_filter_pes_assembler_top; self-checking against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import tspes_pkg::*;

  localparam int PKT = 188;
  localparam int LIMIT = 2000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  ts_pid_filter_pes_assembler_top #(.PACKET_BYTES(PKT)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Predictor state
  logic [12:0] pid_cfg;
  logic [7:0]  p_pos, p_aflen, p_afflags;
  logic [23:0] p_hdr;
  logic [47:0] p_pcrsh;
  logic [3:0]  p_lastcc;
  logic        p_seen, p_asm;
  logic [15:0] p_len;
  logic [16:0] p_cnt;
  logic [2:0]  p_st;

  out_item_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;

  // One row of the directed packet table
  typedef struct packed {
    logic [12:0] pid;
    logic        pusi;
    logic [3:0]  cc;
    logic        af;
    logic        pl;
    logic [7:0]  aflen;
    logic        pcrflag;
    logic        start_mark;
    logic [15:0] pes_len;
  } pkt_row_t;

  // Continuation, lost counter, adaptation-only PCR, oversized adaptation with restart
  localparam pkt_row_t DIR_ROWS [4] = '{
    '{13'd0, 1'b0, 4'd1,  1'b0, 1'b1, 8'd0,   1'b0, 1'b1, 16'd0},
    '{13'd0, 1'b0, 4'd9,  1'b0, 1'b1, 8'd0,   1'b0, 1'b1, 16'd0},
    '{13'd0, 1'b0, 4'd9,  1'b1, 1'b0, 8'd183, 1'b1, 1'b1, 16'd0},
    '{13'd0, 1'b1, 4'd10, 1'b1, 1'b1, 8'd255, 1'b1, 1'b1, 16'd10}
  };

  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    $display("%s: got %h want %h", what, got, want);
  endtask

  task automatic predictor_reset();
    p_pos = 0; p_hdr = 0; p_aflen = 0; p_afflags = 0; p_pcrsh = 0;
    p_lastcc = 0; p_seen = 0; p_asm = 0; p_len = 0; p_cnt = 0; p_st = ST_IGNORED;
  endtask

  // Classify the packet once header byte 3 is in
  task automatic decide();
    logic [12:0] pid;
    logic [3:0] cc, exp_cc;
    pid = p_hdr[20:8];
    cc = p_hdr[3:0];
    exp_cc = p_hdr[4] ? p_lastcc + 4'd1 : p_lastcc;
    if (pid != pid_cfg) begin
      p_st = ST_IGNORED;
    end else if (p_seen && cc != exp_cc) begin
      p_st = ST_LOST;
      p_lastcc = cc;
    end else begin
      p_seen = 1; p_lastcc = cc;
      if (p_hdr[22]) begin
        p_st = p_asm ? ST_FIN_START : ST_STARTED;
        p_asm = 1; p_cnt = 0; p_len = 0;
      end else if (p_asm) p_st = ST_CONTINUE;
      else p_st = ST_IGNORED;
    end
  endtask

  // Compute the results of one accepted byte and queue them
  task automatic predict_byte(in_item_t it);
    logic [7:0] b, pos;
    int start, n;
    out_item_t r;
    logic [47:0] base;
    b = it.in_byte;
    n = 0;
    if (it.packet_start) p_pos = 0;
    pos = p_pos;
    if (pos == 0) begin
      p_hdr = 0; p_aflen = 0; p_afflags = 0; p_pcrsh = 0; p_st = ST_IGNORED;
    end else if (pos <= 3) begin
      p_hdr = {p_hdr[15:0], b};
      if (pos == 3) decide();
    end else begin
      start = 4;
      if (p_hdr[5]) begin
        if (pos == 4) p_aflen = b;
        else if (pos == 5 && p_aflen >= 1) p_afflags = b;
        else if (pos >= 6 && pos <= 11 && p_aflen >= 7 && p_afflags[4])
          p_pcrsh = {p_pcrsh[39:0], b};
        start = 5 + p_aflen;
      end
      if (p_hdr[4] && pos >= start && p_st >= ST_STARTED && p_st <= ST_CONTINUE) begin
        r = '0;
        r.out_byte = b;
        r.status = p_st;
        r.pes_first = (p_st != ST_CONTINUE && pos == start);
        if (p_cnt == 4) p_len[15:8] = b;
        else if (p_cnt == 5) p_len[7:0] = b;
        if (p_cnt < COUNT_MAX) p_cnt++;
        expected_q.push_back(r);
        n++;
      end
    end
    if (pos == PKT - 1) begin
      r = '0;
      r.is_report = 1;
      if (p_st == ST_CONTINUE && p_len != 0 && p_cnt == {1'b0, p_len} + 17'd6) begin
        p_st = ST_FINISHED; p_asm = 0;
      end
      if (p_hdr[5] && p_aflen >= 7 && p_afflags[4]) begin
        base = p_pcrsh >> 15;
        r.pcr_present = 1;
        r.pcr = 42'(base * 300 + p_pcrsh[8:0]);
      end
      r.status = p_st;
      expected_q.push_back(r);
      n++;
    end
    if (n > 0) expected_q[$].last = 1;
    p_pos = (pos + 1 >= PKT) ? 8'd0 : pos + 8'd1;
  endtask

  // Stimulus store: bytes with their packet-start marks
  in_item_t stim_q[$];

  task automatic push_byte(logic [7:0] b, logic ps);
    in_item_t it;
    it.in_byte = b;
    it.packet_start = ps;
    stim_q.push_back(it);
  endtask

  // Build one packet: header, optional adaptation field, random payload with the PES length when pusi is set
  task automatic build_packet(logic [12:0] pid, bit pusi, logic [3:0] cc, bit af, bit pl,
                              int aflen, bit pcrflag, bit start_mark, int pes_len);
    int pos;
    push_byte(8'h47, start_mark);
    push_byte({1'b0, pusi, 1'b0, pid[12:8]}, 0);
    push_byte(pid[7:0], 0);
    push_byte({2'b00, af, pl, cc}, 0);
    pos = 4;
    if (af) begin
      push_byte(aflen[7:0], 0); pos++;
      if (aflen >= 1) begin
        push_byte(pcrflag ? 8'h10 | 8'($urandom_range(0, 255) & 8'hEF)
                          : 8'($urandom_range(0, 255) & 8'hEF), 0);
        pos++;
      end
      while (pos < 5 + aflen && pos < PKT) begin
        push_byte(8'($urandom), 0); pos++;
      end
    end
    while (pos < PKT) begin
      if (pusi && pos - (af ? 5 + aflen : 4) == 4) push_byte(8'(pes_len >> 8), 0);
      else if (pusi && pos - (af ? 5 + aflen : 4) == 5) push_byte(8'(pes_len), 0);
      else push_byte(8'($urandom), 0);
      pos++;
    end
  endtask

  // Driver state
  in_item_t cur;
  bit have_cur = 0;
  int phase = 0;

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Sender: hold valid until accepted, then advance, with random gaps in phases 1 and 3
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_byte(in_data);
        have_cur = 0;
      end
      if (!have_cur && stim_q.size() > 0 &&
          !((phase == 1 || phase == 3) && chance(phase == 3 ? 19 : 78))) begin
        cur = stim_q.pop_front();
        have_cur = 1;
        in_data <= cur;
        in_valid <= 1;
      end else if (!have_cur) begin
        in_valid <= 0;
      end
    end
  end

  // Receiver: stall by phase, and hold off long when asked
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) report("unexpected result", out_data, '0);
        else begin
          out_item_t w;
          w = expected_q.pop_front();
          if (out_data !== w) report("result mismatch", out_data, w);
        end
      end
      if (hold_off) out_ready <= 0;
      else out_ready <= !((phase == 2 || phase == 3) && chance(phase == 3 ? 19 : 78));
    end
  end

  task automatic wait_drained();
    while (stim_q.size() > 0 || have_cur || in_valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [12:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_TARGET_PID; pwdata <= {19'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    pid_cfg = v;
  endtask

  // Random traffic: mostly well-formed streams on the target PID, some noise
  task automatic random_stream(int npkts);
    logic [3:0] cc;
    int aflen, pes_len;
    bit pusi, af, pl;
    cc = 4'($urandom);
    for (int k = 0; k < npkts; k++) begin
      pusi = chance(30);
      af = chance(40);
      pl = chance(90) || !af;
      aflen = chance(80) ? $urandom_range(0, 20) : $urandom_range(0, 255);
      pes_len = chance(60) ? $urandom_range(1, 300) : $urandom_range(0, 65535);
      if (chance(85)) begin
        if (pl) cc = chance(90) ? cc + 4'd1 : 4'($urandom);
        build_packet(pid_cfg, pusi, cc, af, pl, aflen, chance(60), chance(70), pes_len);
      end else if (chance(50)) begin
        build_packet(13'($urandom), pusi, 4'($urandom), af, pl, aflen, chance(50),
                     chance(70), pes_len);
      end else begin
        // Short packet cut by the next start, or raw noise
        int len;
        len = $urandom_range(1, 60);
        for (int j = 0; j < len; j++) push_byte(8'($urandom), j == 0);
      end
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    pid_cfg = 0;
    predictor_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Directed: packet at reset without a start mark, PID 0, extremes of bytes
    phase = 0;
    push_byte(8'hFF, 0); push_byte(8'h40, 0); push_byte(8'h00, 0); push_byte(8'h10, 0);
    for (int j = 4; j < PKT; j++) push_byte(j[0] ? 8'hFF : 8'h00, 0);
    // Walk the directed packet table
    foreach (DIR_ROWS[i]) begin
      build_packet(DIR_ROWS[i].pid, DIR_ROWS[i].pusi, DIR_ROWS[i].cc, DIR_ROWS[i].af,
                   DIR_ROWS[i].pl, int'(DIR_ROWS[i].aflen), DIR_ROWS[i].pcrflag,
                   DIR_ROWS[i].start_mark, int'(DIR_ROWS[i].pes_len));
    end
    wait_drained();

    // Long receiver hold-off on the highest PID while the sender keeps going
    cfg_write(13'h1FFF);
    random_stream(1);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      phase = ph;
      cfg_write(ph == 0 ? 13'd0 : 13'($urandom));
      random_stream(1);
      wait_drained();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
